@@ sv/isc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// isc_pkg: shared types and constants of the IMU sample conditioner
// Field widths, scaling constants, reciprocals for the constant dividers,
// register map codes and the filter lane control bundle.
// ----------------------------------------------------------------------------
package isc_pkg;

  localparam int RAW_W   = 16;
  localparam int ACC_W   = 13;
  localparam int RATE_W  = 19;
  localparam int TEMP_W  = 15;
  localparam int SHIFT_W = 4;
  localparam int LANE_W  = 19;   // filter lanes carry the wider of the two axis types
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // Acceleration: raw * 1000 / 16384, half added before truncation.
  localparam logic [9:0]  ACC_SCALE     = 10'd1000;
  localparam logic [13:0] ACC_HALF      = 14'd8192;
  localparam int          ACC_FRAC_BITS = 14;
  localparam int          ACC_LIMIT     = 4000;

  // Rotation rate: raw * 1000 / 131. RATE_RECIP is floor(2^32 / 131).
  localparam logic [9:0]  RATE_SCALE = 10'd1000;
  localparam logic [6:0]  RATE_HALF  = 7'd65;
  localparam logic [7:0]  RATE_DIV   = 8'd131;
  localparam logic [24:0] RATE_RECIP = 25'd32786009;
  localparam int          RATE_LIMIT = 250000;

  // Temperature: raw * 100 / 340 + 3653. TEMP_RECIP is floor(2^32 / 340).
  localparam logic [6:0]         TEMP_SCALE = 7'd100;
  localparam logic [7:0]         TEMP_HALF  = 8'd169;
  localparam logic [8:0]         TEMP_DIV   = 9'd340;
  localparam logic [23:0]        TEMP_RECIP = 24'd12632256;
  localparam logic signed [14:0] TEMP_BIAS  = 15'sd3653;

  localparam int RECIP_BITS = 32;

  localparam logic [SHIFT_W-1:0] ACC_SHIFT_RST  = 4'd3;
  localparam logic [SHIFT_W-1:0] RATE_SHIFT_RST = 4'd2;

  typedef enum logic [2:0] {
    REG_ACC_X_OFF   = 3'd0,
    REG_ACC_Y_OFF   = 3'd1,
    REG_ACC_Z_OFF   = 3'd2,
    REG_RATE_X_OFF  = 3'd3,
    REG_RATE_Y_OFF  = 3'd4,
    REG_RATE_Z_OFF  = 3'd5,
    REG_ACC_SHIFT   = 3'd6,
    REG_RATE_SHIFT  = 3'd7
  } isc_reg_e;

  typedef struct packed {
    logic en;      // a sample leaves the front pipeline this cycle
    logic clr;     // an offset write zeroes the history
    logic primed;  // smoother already holds a value
  } isc_filt_ctrl_t;

endpackage
`default_nettype wire

@@ sv/imu_sample_conditioner_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// imu_sample_conditioner_unit: six-axis IMU frame conditioner
// Path: a frame accepted at the input passes four scaling stages per lane,
//   then the filter/output reg.
// Throughput: one frame per cycle unless the output is held; the median and
//   smoother update of each axis closes on its own state, which sets the rate.
// Reset: configuration returns to its reset values, histories clear, the
//   pipeline empties; no clearing pass is needed.
// ----------------------------------------------------------------------------
module imu_sample_conditioner_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [isc_pkg::RAW_W-1:0]     accel_x_raw_i,
  input  logic signed [isc_pkg::RAW_W-1:0]     accel_y_raw_i,
  input  logic signed [isc_pkg::RAW_W-1:0]     accel_z_raw_i,
  input  logic signed [isc_pkg::RAW_W-1:0]     rate_x_raw_i,
  input  logic signed [isc_pkg::RAW_W-1:0]     rate_y_raw_i,
  input  logic signed [isc_pkg::RAW_W-1:0]     rate_z_raw_i,
  input  logic signed [isc_pkg::RAW_W-1:0]     temp_raw_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [isc_pkg::ACC_W-1:0]     accel_x_smooth_o,
  output logic signed [isc_pkg::ACC_W-1:0]     accel_y_smooth_o,
  output logic signed [isc_pkg::ACC_W-1:0]     accel_z_smooth_o,
  output logic signed [isc_pkg::RATE_W-1:0]    rate_x_smooth_o,
  output logic signed [isc_pkg::RATE_W-1:0]    rate_y_smooth_o,
  output logic signed [isc_pkg::RATE_W-1:0]    rate_z_smooth_o,
  output logic signed [isc_pkg::TEMP_W-1:0]    temp_centideg_o,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [isc_pkg::ADDR_W-1:0]           paddr,
  input  logic [isc_pkg::DATA_W-1:0]           pwdata,
  output logic [isc_pkg::DATA_W-1:0]           prdata,
  output logic                                 pready
);

  // Configuration registers.
  logic signed [isc_pkg::ACC_W-1:0]  acc_off_q  [3];
  logic signed [isc_pkg::RATE_W-1:0] rate_off_q [3];
  logic [isc_pkg::SHIFT_W-1:0]       acc_shift_q, rate_shift_q;

  isc_pkg::isc_reg_e reg_idx;
  logic              cfg_wr;
  logic [2:0]        acc_off_wr, rate_off_wr;
  logic              acc_shift_wr, rate_shift_wr, offset_wr;

  // Pipeline control.
  logic [3:0] vld_q;
  logic       out_valid_q;
  logic       advance;
  logic       filt_en;
  logic       primed_q;

  isc_pkg::isc_filt_ctrl_t filt_ctrl;

  logic signed [isc_pkg::RAW_W-1:0]  acc_raw   [3];
  logic signed [isc_pkg::RAW_W-1:0]  rate_raw  [3];
  logic signed [isc_pkg::ACC_W-1:0]  acc_clip  [3];
  logic signed [isc_pkg::RATE_W-1:0] rate_clip [3];
  logic signed [isc_pkg::LANE_W-1:0] acc_sm    [3];
  logic signed [isc_pkg::LANE_W-1:0] rate_sm   [3];
  logic signed [isc_pkg::TEMP_W-1:0] temp_val;

  logic signed [isc_pkg::ACC_W-1:0]  acc_out_q  [3];
  logic signed [isc_pkg::RATE_W-1:0] rate_out_q [3];
  logic signed [isc_pkg::TEMP_W-1:0] temp_out_q;

  // --------------------------------------------------------------------------
  // Register decode and storage
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = isc_pkg::isc_reg_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    acc_off_wr    = '0;
    rate_off_wr   = '0;
    acc_shift_wr  = 1'b0;
    rate_shift_wr = 1'b0;
    unique case (reg_idx)
      isc_pkg::REG_ACC_X_OFF:  acc_off_wr[0]  = cfg_wr;
      isc_pkg::REG_ACC_Y_OFF:  acc_off_wr[1]  = cfg_wr;
      isc_pkg::REG_ACC_Z_OFF:  acc_off_wr[2]  = cfg_wr;
      isc_pkg::REG_RATE_X_OFF: rate_off_wr[0] = cfg_wr;
      isc_pkg::REG_RATE_Y_OFF: rate_off_wr[1] = cfg_wr;
      isc_pkg::REG_RATE_Z_OFF: rate_off_wr[2] = cfg_wr;
      isc_pkg::REG_ACC_SHIFT:  acc_shift_wr   = cfg_wr;
      isc_pkg::REG_RATE_SHIFT: rate_shift_wr  = cfg_wr;
      default: ;
    endcase
  end

  always_comb begin
    unique case (reg_idx) inside
      isc_pkg::REG_ACC_X_OFF, isc_pkg::REG_ACC_Y_OFF, isc_pkg::REG_ACC_Z_OFF,
      isc_pkg::REG_RATE_X_OFF, isc_pkg::REG_RATE_Y_OFF, isc_pkg::REG_RATE_Z_OFF:
        offset_wr = cfg_wr;
      default:
        offset_wr = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        acc_off_q[i]  <= '0;
        rate_off_q[i] <= '0;
      end
      acc_shift_q  <= isc_pkg::ACC_SHIFT_RST;
      rate_shift_q <= isc_pkg::RATE_SHIFT_RST;
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (acc_off_wr[i]) begin
          acc_off_q[i] <= pwdata[isc_pkg::ACC_W-1:0];
        end
        if (rate_off_wr[i]) begin
          rate_off_q[i] <= pwdata[isc_pkg::RATE_W-1:0];
        end
      end
      if (acc_shift_wr) begin
        acc_shift_q <= pwdata[isc_pkg::SHIFT_W-1:0];
      end
      if (rate_shift_wr) begin
        rate_shift_q <= pwdata[isc_pkg::SHIFT_W-1:0];
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      isc_pkg::REG_ACC_X_OFF:  prdata = 32'(acc_off_q[0]);
      isc_pkg::REG_ACC_Y_OFF:  prdata = 32'(acc_off_q[1]);
      isc_pkg::REG_ACC_Z_OFF:  prdata = 32'(acc_off_q[2]);
      isc_pkg::REG_RATE_X_OFF: prdata = 32'(rate_off_q[0]);
      isc_pkg::REG_RATE_Y_OFF: prdata = 32'(rate_off_q[1]);
      isc_pkg::REG_RATE_Z_OFF: prdata = 32'(rate_off_q[2]);
      isc_pkg::REG_ACC_SHIFT:  prdata = 32'(acc_shift_q);
      isc_pkg::REG_RATE_SHIFT: prdata = 32'(rate_shift_q);
      default:                 prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control: every stage moves together unless the output is held.
  // --------------------------------------------------------------------------
  assign advance    = !(out_valid_q && out_stall_i);
  assign in_stall_o = !advance;
  assign filt_en    = advance && vld_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      vld_q       <= {vld_q[2:0], in_valid_i};
      out_valid_q <= vld_q[3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
    end else if (offset_wr) begin
      primed_q <= 1'b0;
    end else if (filt_en) begin
      primed_q <= 1'b1;
    end
  end

  assign filt_ctrl.en     = filt_en;
  assign filt_ctrl.clr    = offset_wr;
  assign filt_ctrl.primed = primed_q;

  // --------------------------------------------------------------------------
  // Lanes
  // --------------------------------------------------------------------------
  assign acc_raw[0]  = accel_x_raw_i;
  assign acc_raw[1]  = accel_y_raw_i;
  assign acc_raw[2]  = accel_z_raw_i;
  assign rate_raw[0] = rate_x_raw_i;
  assign rate_raw[1] = rate_y_raw_i;
  assign rate_raw[2] = rate_z_raw_i;

  for (genvar g = 0; g < 3; g++) begin : g_axis
    isc_accel_front u_acc_front (
      .clk_i (clk_i),
      .en_i  (advance),
      .raw_i (acc_raw[g]),
      .off_i (acc_off_q[g]),
      .acc_o (acc_clip[g])
    );

    isc_rate_front u_rate_front (
      .clk_i  (clk_i),
      .en_i   (advance),
      .raw_i  (rate_raw[g]),
      .off_i  (rate_off_q[g]),
      .rate_o (rate_clip[g])
    );

    isc_filter u_acc_filter (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (filt_ctrl),
      .shift_i  (acc_shift_q),
      .x_i      (isc_pkg::LANE_W'(acc_clip[g])),
      .smooth_o (acc_sm[g])
    );

    isc_filter u_rate_filter (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (filt_ctrl),
      .shift_i  (rate_shift_q),
      .x_i      (rate_clip[g]),
      .smooth_o (rate_sm[g])
    );
  end

  isc_temp_front u_temp_front (
    .clk_i  (clk_i),
    .en_i   (advance),
    .raw_i  (temp_raw_i),
    .temp_o (temp_val)
  );

  // --------------------------------------------------------------------------
  // Output register: gathers all lanes into one transaction.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (filt_en) begin
      for (int i = 0; i < 3; i++) begin
        acc_out_q[i]  <= acc_sm[i][isc_pkg::ACC_W-1:0];
        rate_out_q[i] <= rate_sm[i][isc_pkg::RATE_W-1:0];
      end
      temp_out_q <= temp_val;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign accel_x_smooth_o = acc_out_q[0];
  assign accel_y_smooth_o = acc_out_q[1];
  assign accel_z_smooth_o = acc_out_q[2];
  assign rate_x_smooth_o  = rate_out_q[0];
  assign rate_y_smooth_o  = rate_out_q[1];
  assign rate_z_smooth_o  = rate_out_q[2];
  assign temp_centideg_o  = temp_out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_offset_unprimes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    offset_wr |=> !primed_q)
    else $error("smoother still primed after an offset write");

  a_last_stage_reaches_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[3] && !in_stall_o) |=> out_valid_o)
    else $error("sample leaving the scaling pipeline was lost");

  a_primed_by_sample : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(primed_q) |-> $past(filt_en))
    else $error("smoother primed without a filtered sample");

endmodule
`default_nettype wire

@@ sv/isc_accel_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// isc_accel_front: acceleration scaling lane
// Four stages: magnitude times 1000 plus half, shift by 14 and sign restore,
// alignment, offset subtraction and clamp to +/-4000 milli-g.
// ----------------------------------------------------------------------------
module isc_accel_front (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [isc_pkg::RAW_W-1:0]    raw_i,
  input  logic signed [isc_pkg::ACC_W-1:0]    off_i,
  output logic signed [isc_pkg::ACC_W-1:0]    acc_o
);

  logic [15:0]        abs_d;
  logic [24:0]        mag_d, mag_q;
  logic               neg_q;
  logic [10:0]        quo;
  logic signed [11:0] val_d, val_q, val2_q;
  logic signed [13:0] diff;
  logic signed [12:0] clip_d, clip_q;

  always_comb begin
    abs_d = raw_i[15] ? (~raw_i + 16'd1) : raw_i;
    mag_d = 25'(abs_d) * 25'(isc_pkg::ACC_SCALE) + 25'(isc_pkg::ACC_HALF);
  end

  always_comb begin
    quo   = 11'(mag_q >> isc_pkg::ACC_FRAC_BITS);
    val_d = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

  always_comb begin
    diff = $signed({{2{val2_q[11]}}, val2_q}) - $signed({off_i[12], off_i});
    if (diff > 14'(isc_pkg::ACC_LIMIT)) begin
      clip_d = 13'(isc_pkg::ACC_LIMIT);
    end else if (diff < 14'(-isc_pkg::ACC_LIMIT)) begin
      clip_d = 13'(-isc_pkg::ACC_LIMIT);
    end else begin
      clip_d = diff[12:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_d;
      neg_q  <= raw_i[15];
      val_q  <= val_d;
      val2_q <= val_q;
      clip_q <= clip_d;
    end
  end

  assign acc_o = clip_q;

endmodule
`default_nettype wire

@@ sv/isc_rate_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// isc_rate_front: rotation rate scaling lane
// Four stages: magnitude times 1000 plus half, reciprocal multiply for the
// divide by 131, one-step quotient correction with sign restore, then offset
// subtraction and clamp to +/-250000 milli-degrees per second.
// ----------------------------------------------------------------------------
module isc_rate_front (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [isc_pkg::RAW_W-1:0]    raw_i,
  input  logic signed [isc_pkg::RATE_W-1:0]   off_i,
  output logic signed [isc_pkg::RATE_W-1:0]   rate_o
);

  logic [15:0]        abs_d;
  logic [24:0]        mag_d, mag_q, mag2_q;
  logic               neg_q, neg2_q;
  logic [49:0]        prod;
  logic [17:0]        qest_d, qest_q;
  logic [24:0]        rem;
  logic [17:0]        quo;
  logic signed [18:0] val_d, val_q;
  logic signed [19:0] diff;
  logic signed [18:0] clip_d, clip_q;

  always_comb begin
    abs_d = raw_i[15] ? (~raw_i + 16'd1) : raw_i;
    mag_d = 25'(abs_d) * 25'(isc_pkg::RATE_SCALE) + 25'(isc_pkg::RATE_HALF);
  end

  // The truncated reciprocal can only come out one below the true quotient.
  always_comb begin
    prod   = 50'(mag_q) * 50'(isc_pkg::RATE_RECIP);
    qest_d = prod[isc_pkg::RECIP_BITS +: 18];
  end

  always_comb begin
    rem   = mag2_q - 25'(qest_q) * 25'(isc_pkg::RATE_DIV);
    quo   = qest_q + 18'(rem >= 25'(isc_pkg::RATE_DIV));
    val_d = neg2_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

  always_comb begin
    diff = $signed({val_q[18], val_q}) - $signed({off_i[18], off_i});
    if (diff > 20'(isc_pkg::RATE_LIMIT)) begin
      clip_d = 19'(isc_pkg::RATE_LIMIT);
    end else if (diff < 20'(-isc_pkg::RATE_LIMIT)) begin
      clip_d = 19'(-isc_pkg::RATE_LIMIT);
    end else begin
      clip_d = diff[18:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_d;
      neg_q  <= raw_i[15];
      qest_q <= qest_d;
      mag2_q <= mag_q;
      neg2_q <= neg_q;
      val_q  <= val_d;
      clip_q <= clip_d;
    end
  end

  assign rate_o = clip_q;

endmodule
`default_nettype wire

@@ sv/isc_temp_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// isc_temp_front: temperature conversion lane
// Four stages: magnitude times 100 plus half, reciprocal multiply for the
// divide by 340, quotient correction with sign restore, then the fixed bias.
// ----------------------------------------------------------------------------
module isc_temp_front (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [isc_pkg::RAW_W-1:0]    raw_i,
  output logic signed [isc_pkg::TEMP_W-1:0]   temp_o
);

  logic [15:0]        abs_d;
  logic [21:0]        mag_d, mag_q, mag2_q;
  logic               neg_q, neg2_q;
  logic [45:0]        prod;
  logic [13:0]        qest_d, qest_q;
  logic [21:0]        rem;
  logic [13:0]        quo;
  logic signed [14:0] val_d, val_q;
  logic signed [14:0] temp_q;

  always_comb begin
    abs_d = raw_i[15] ? (~raw_i + 16'd1) : raw_i;
    mag_d = 22'(abs_d) * 22'(isc_pkg::TEMP_SCALE) + 22'(isc_pkg::TEMP_HALF);
  end

  always_comb begin
    prod   = 46'(mag_q) * 46'(isc_pkg::TEMP_RECIP);
    qest_d = prod[isc_pkg::RECIP_BITS +: 14];
  end

  always_comb begin
    rem   = mag2_q - 22'(qest_q) * 22'(isc_pkg::TEMP_DIV);
    quo   = qest_q + 14'(rem >= 22'(isc_pkg::TEMP_DIV));
    val_d = neg2_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_d;
      neg_q  <= raw_i[15];
      qest_q <= qest_d;
      mag2_q <= mag_q;
      neg2_q <= neg_q;
      val_q  <= val_d;
      temp_q <= val_q + isc_pkg::TEMP_BIAS;
    end
  end

  assign temp_o = temp_q;

endmodule
`default_nettype wire

@@ sv/isc_filter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// isc_filter: median-of-three and exponential smoother for one axis
// Keeps the two previous clamped samples and the smoothed value. The new
// smoothed value is presented combinationally for the output register.
// ----------------------------------------------------------------------------
module isc_filter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  isc_pkg::isc_filt_ctrl_t              ctrl_i,
  input  logic [isc_pkg::SHIFT_W-1:0]          shift_i,
  input  logic signed [isc_pkg::LANE_W-1:0]    x_i,
  output logic signed [isc_pkg::LANE_W-1:0]    smooth_o
);

  logic signed [isc_pkg::LANE_W-1:0] h0_q, h1_q, s_q, s_d;
  logic signed [isc_pkg::LANE_W-1:0] lo, hi, med;
  logic signed [isc_pkg::LANE_W:0]   diff, step, sum;

  always_comb begin
    lo = (h0_q < h1_q) ? h0_q : h1_q;
    hi = (h0_q < h1_q) ? h1_q : h0_q;
    if (x_i <= lo) begin
      med = lo;
    end else if (x_i >= hi) begin
      med = hi;
    end else begin
      med = x_i;
    end
    diff = $signed({med[isc_pkg::LANE_W-1], med}) - $signed({s_q[isc_pkg::LANE_W-1], s_q});
    step = diff >>> shift_i;
    sum  = $signed({s_q[isc_pkg::LANE_W-1], s_q}) + step;
    // The first sample after reset or an offset change loads the smoother.
    s_d  = ctrl_i.primed ? sum[isc_pkg::LANE_W-1:0] : med;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h0_q <= '0;
      h1_q <= '0;
    end else if (ctrl_i.clr) begin
      h0_q <= '0;
      h1_q <= '0;
    end else if (ctrl_i.en) begin
      h1_q <= h0_q;
      h0_q <= x_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      s_q <= s_d;
    end
  end

  assign smooth_o = s_d;

endmodule
`default_nettype wire

@@ sim/imu_sample_conditioner_unit_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// imu_sample_conditioner_unit_tb: self-checking bench for the IMU conditioner
// Drives raw sensor frames through the valid/stall input channel and programs
// offsets and smoothing shifts over the APB port. A local model of the
// scaling, clamping, median and smoothing path predicts each conditioned
// frame, and every output transaction is compared field by field.
// ----------------------------------------------------------------------------
module imu_sample_conditioner_unit_tb;

  localparam int RUN_LIMIT    = 100000;
  localparam int PIPE_SETTLE  = 8;
  localparam int ACC_OFF_MAX  = 4095;
  localparam int RATE_OFF_MAX = 262143;

  typedef struct packed {
    logic signed [isc_pkg::RAW_W-1:0] ax, ay, az, rx, ry, rz, temp;
  } imu_frame_t;

  typedef struct packed {
    logic signed [isc_pkg::ACC_W-1:0]  ax, ay, az;
    logic signed [isc_pkg::RATE_W-1:0] rx, ry, rz;
    logic signed [isc_pkg::TEMP_W-1:0] temp;
  } imu_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [isc_pkg::RAW_W-1:0] accel_x_raw_i = '0;
  logic signed [isc_pkg::RAW_W-1:0] accel_y_raw_i = '0;
  logic signed [isc_pkg::RAW_W-1:0] accel_z_raw_i = '0;
  logic signed [isc_pkg::RAW_W-1:0] rate_x_raw_i = '0;
  logic signed [isc_pkg::RAW_W-1:0] rate_y_raw_i = '0;
  logic signed [isc_pkg::RAW_W-1:0] rate_z_raw_i = '0;
  logic signed [isc_pkg::RAW_W-1:0] temp_raw_i = '0;

  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [isc_pkg::ACC_W-1:0]  accel_x_smooth_o;
  logic signed [isc_pkg::ACC_W-1:0]  accel_y_smooth_o;
  logic signed [isc_pkg::ACC_W-1:0]  accel_z_smooth_o;
  logic signed [isc_pkg::RATE_W-1:0] rate_x_smooth_o;
  logic signed [isc_pkg::RATE_W-1:0] rate_y_smooth_o;
  logic signed [isc_pkg::RATE_W-1:0] rate_z_smooth_o;
  logic signed [isc_pkg::TEMP_W-1:0] temp_centideg_o;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [isc_pkg::ADDR_W-1:0] paddr = '0;
  logic [isc_pkg::DATA_W-1:0] pwdata = '0;
  logic [isc_pkg::DATA_W-1:0] prdata;
  logic pready;

  // Model state: configuration, per-axis history and smoother values.
  int acc_off [3];
  int rate_off [3];
  int acc_shift;
  int rate_shift;
  int acc_hist [3][2];
  int rate_hist [3][2];
  int acc_sm [3];
  int rate_sm [3];
  bit smoother_primed;

  imu_result_t conditioned_q [$];
  imu_result_t oldest;
  imu_frame_t prev_frame = '0;

  int mismatches = 0;
  int cycle_count = 0;
  int sink_hold_cycles = 0;
  bit no_idle = 1'b0;

  imu_sample_conditioner_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .accel_x_raw_i    (accel_x_raw_i),
    .accel_y_raw_i    (accel_y_raw_i),
    .accel_z_raw_i    (accel_z_raw_i),
    .rate_x_raw_i     (rate_x_raw_i),
    .rate_y_raw_i     (rate_y_raw_i),
    .rate_z_raw_i     (rate_z_raw_i),
    .temp_raw_i       (temp_raw_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .accel_x_smooth_o (accel_x_smooth_o),
    .accel_y_smooth_o (accel_y_smooth_o),
    .accel_z_smooth_o (accel_z_smooth_o),
    .rate_x_smooth_o  (rate_x_smooth_o),
    .rate_y_smooth_o  (rate_y_smooth_o),
    .rate_z_smooth_o  (rate_z_smooth_o),
    .temp_centideg_o  (temp_centideg_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // ---------------------------------------------------------------- model

  function automatic void clear_filter_state();
    for (int i = 0; i < 3; i++) begin
      acc_hist[i][0] = 0;
      acc_hist[i][1] = 0;
      rate_hist[i][0] = 0;
      rate_hist[i][1] = 0;
      acc_sm[i] = 0;
      rate_sm[i] = 0;
    end
    acc_sm[2] = 1000;
    smoother_primed = 1'b0;
  endfunction

  // Division truncates toward zero, so a signed half term rounds away from zero.
  function automatic int div_round(int num, int half, int divisor);
    return (num + ((num >= 0) ? half : -half)) / divisor;
  endfunction

  function automatic int clamp_to(int x, int lim);
    if (x < -lim) return -lim;
    if (x > lim) return lim;
    return x;
  endfunction

  function automatic int median3(int a, int b, int c);
    int lo;
    int hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) return lo;
    if (c >= hi) return hi;
    return c;
  endfunction

  function automatic imu_result_t condition_frame(imu_frame_t f);
    imu_result_t r;
    int acc_raw [3];
    int rate_raw [3];
    int acc_v;
    int rate_v;
    int m;
    acc_raw[0] = f.ax;
    acc_raw[1] = f.ay;
    acc_raw[2] = f.az;
    rate_raw[0] = f.rx;
    rate_raw[1] = f.ry;
    rate_raw[2] = f.rz;
    for (int i = 0; i < 3; i++) begin
      acc_v = clamp_to(div_round(acc_raw[i] * 1000, 8192, 16384) - acc_off[i],
                       isc_pkg::ACC_LIMIT);
      rate_v = clamp_to(div_round(rate_raw[i] * 1000, 65, 131) - rate_off[i],
                        isc_pkg::RATE_LIMIT);

      m = median3(acc_hist[i][0], acc_hist[i][1], acc_v);
      acc_hist[i][1] = acc_hist[i][0];
      acc_hist[i][0] = acc_v;
      acc_sm[i] = smoother_primed ? acc_sm[i] + ((m - acc_sm[i]) >>> acc_shift) : m;

      m = median3(rate_hist[i][0], rate_hist[i][1], rate_v);
      rate_hist[i][1] = rate_hist[i][0];
      rate_hist[i][0] = rate_v;
      rate_sm[i] = smoother_primed ? rate_sm[i] + ((m - rate_sm[i]) >>> rate_shift) : m;
    end
    smoother_primed = 1'b1;
    r.ax = acc_sm[0][isc_pkg::ACC_W-1:0];
    r.ay = acc_sm[1][isc_pkg::ACC_W-1:0];
    r.az = acc_sm[2][isc_pkg::ACC_W-1:0];
    r.rx = rate_sm[0][isc_pkg::RATE_W-1:0];
    r.ry = rate_sm[1][isc_pkg::RATE_W-1:0];
    r.rz = rate_sm[2][isc_pkg::RATE_W-1:0];
    m = div_round(int'(f.temp) * 100, 169, 340) + 3653;
    r.temp = m[isc_pkg::TEMP_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic imu_frame_t frame_of(int ax, int ay, int az, int rx, int ry, int rz,
                                          int tt);
    imu_frame_t f;
    f.ax = ax[isc_pkg::RAW_W-1:0];
    f.ay = ay[isc_pkg::RAW_W-1:0];
    f.az = az[isc_pkg::RAW_W-1:0];
    f.rx = rx[isc_pkg::RAW_W-1:0];
    f.ry = ry[isc_pkg::RAW_W-1:0];
    f.rz = rz[isc_pkg::RAW_W-1:0];
    f.temp = tt[isc_pkg::RAW_W-1:0];
    return f;
  endfunction

  // Values at or just inside either end of the raw range; the outermost of
  // these reach the rate clamp.
  function automatic logic [isc_pkg::RAW_W-1:0] edge_value();
    int k;
    k = $urandom_range(0, 31);
    return $urandom_range(0, 1) ? 16'(32767 - k) : 16'(-32768 + k);
  endfunction

  function automatic logic [isc_pkg::RAW_W-1:0] walk_step();
    return 16'(int'($urandom_range(0, 256)) - 128);
  endfunction

  // Mix of full-range noise, slowly drifting frames (where the median and the
  // smoother do real work), frames pinned at the range ends and single spikes.
  function automatic imu_frame_t random_frame();
    imu_frame_t f;
    logic [127:0] bits;
    int mode;
    mode = $urandom_range(0, 9);
    bits = {$urandom, $urandom, $urandom, $urandom};
    f = bits[111:0];
    if (mode >= 4 && mode <= 7) begin
      f.ax = prev_frame.ax + walk_step();
      f.ay = prev_frame.ay + walk_step();
      f.az = prev_frame.az + walk_step();
      f.rx = prev_frame.rx + walk_step();
      f.ry = prev_frame.ry + walk_step();
      f.rz = prev_frame.rz + walk_step();
      f.temp = prev_frame.temp + walk_step();
    end else if (mode == 8) begin
      f = {edge_value(), edge_value(), edge_value(), edge_value(), edge_value(),
           edge_value(), edge_value()};
    end else if (mode == 9) begin
      f = prev_frame;
      f.ay = edge_value();
      f.rz = edge_value();
    end
    prev_frame = f;
    return f;
  endfunction

  // Offer one frame and hold it until the block takes it.
  task automatic send_frame(input imu_frame_t f);
    while (!no_idle && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    accel_x_raw_i <= f.ax;
    accel_y_raw_i <= f.ay;
    accel_z_raw_i <= f.az;
    rate_x_raw_i <= f.rx;
    rate_y_raw_i <= f.ry;
    rate_z_raw_i <= f.rz;
    temp_raw_i <= f.temp;
    do @(posedge clk_i); while (in_stall_o);
    conditioned_q.push_back(condition_frame(f));
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_frame(random_frame());
  endtask

  // Stop offering frames and wait until every result is back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (conditioned_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_register(input isc_pkg::isc_reg_e idx, input int value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      isc_pkg::REG_ACC_X_OFF, isc_pkg::REG_ACC_Y_OFF, isc_pkg::REG_ACC_Z_OFF: begin
        acc_off[int'(idx)] = int'($signed(value[isc_pkg::ACC_W-1:0]));
        clear_filter_state();
      end
      isc_pkg::REG_RATE_X_OFF, isc_pkg::REG_RATE_Y_OFF, isc_pkg::REG_RATE_Z_OFF: begin
        rate_off[int'(idx) - int'(isc_pkg::REG_RATE_X_OFF)] =
          int'($signed(value[isc_pkg::RATE_W-1:0]));
        clear_filter_state();
      end
      isc_pkg::REG_ACC_SHIFT: acc_shift = value[isc_pkg::SHIFT_W-1:0];
      isc_pkg::REG_RATE_SHIFT: rate_shift = value[isc_pkg::SHIFT_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic int random_acc_offset();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? ACC_OFF_MAX : -ACC_OFF_MAX - 1;
    return int'($urandom_range(0, 2 * ACC_OFF_MAX + 1)) - ACC_OFF_MAX - 1;
  endfunction

  function automatic int random_rate_offset();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? RATE_OFF_MAX : -RATE_OFF_MAX - 1;
    return int'($urandom_range(0, 2 * RATE_OFF_MAX + 1)) - RATE_OFF_MAX - 1;
  endfunction

  // ---------------------------------------------------------------- sink side

  always @(posedge clk_i) begin
    if (sink_hold_cycles > 0) begin
      sink_hold_cycles = sink_hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !no_idle && ($urandom_range(0, 99) < 25);
    end
  end

  function automatic void check_field(string label, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ERROR %s: expected %0d, actual %0d", $time, label, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (conditioned_q.size() == 0) begin
        mismatches++;
        $display("%0t ERROR result with no frame pending: expected none, actual %0d %0d %0d",
                 $time, accel_x_smooth_o, rate_x_smooth_o, temp_centideg_o);
      end else begin
        oldest = conditioned_q.pop_front();
        check_field("accel_x_smooth", oldest.ax, accel_x_smooth_o);
        check_field("accel_y_smooth", oldest.ay, accel_y_smooth_o);
        check_field("accel_z_smooth", oldest.az, accel_z_smooth_o);
        check_field("rate_x_smooth", oldest.rx, rate_x_smooth_o);
        check_field("rate_y_smooth", oldest.ry, rate_y_smooth_o);
        check_field("rate_z_smooth", oldest.rz, rate_z_smooth_o);
        check_field("temp_centideg", oldest.temp, temp_centideg_o);
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // The first frame after reset loads the smoother directly; the rest of the
  // frames probe range ends and rounding near half a unit.
  task automatic test_reset_priming();
    send_frame(frame_of(0, 0, 0, 0, 0, 0, 0));
    send_frame(frame_of(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_frame(frame_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_frame(frame_of(1, -1, 8, -8, 65, -65, 1));
    send_frame(frame_of(16384, -16384, 8192, 131, -131, 33, -1));
    send_frame(frame_of(-8192, 4096, -4096, 32750, -32750, 32760, 32767));
    send_frame(frame_of(32767, -32768, 0, -32768, 32767, 0, -32768));
    send_frame(frame_of(0, 0, 0, 0, 0, 0, 0));
    drain_results();
  endtask

  // Offsets at both ends of their range drive every axis into its clamp;
  // shift extremes give no smoothing and nearly frozen smoothing.
  task automatic test_register_extremes();
    write_register(isc_pkg::REG_ACC_X_OFF, -ACC_OFF_MAX - 1);
    write_register(isc_pkg::REG_ACC_Y_OFF, ACC_OFF_MAX);
    write_register(isc_pkg::REG_ACC_Z_OFF, -ACC_OFF_MAX - 1);
    write_register(isc_pkg::REG_RATE_X_OFF, -RATE_OFF_MAX - 1);
    write_register(isc_pkg::REG_RATE_Y_OFF, RATE_OFF_MAX);
    write_register(isc_pkg::REG_RATE_Z_OFF, RATE_OFF_MAX);
    write_register(isc_pkg::REG_ACC_SHIFT, 0);
    write_register(isc_pkg::REG_RATE_SHIFT, 15);
    send_frame(frame_of(0, 0, 0, 0, 0, 0, 100));
    send_frame(frame_of(32767, 32767, 32767, 32767, 32767, 32767, 0));
    send_frame(frame_of(-32768, -32768, -32768, -32768, -32768, -32768, -100));
    send_frame(frame_of(32767, -32768, 16384, -32768, 32767, -16384, 2000));
    send_frame(frame_of(-100, 100, -100, 100, -100, 100, -2000));
    drain_results();
    write_register(isc_pkg::REG_ACC_SHIFT, 15);
    write_register(isc_pkg::REG_RATE_SHIFT, 0);
    send_frame(frame_of(32767, 32767, 32767, -32768, -32768, -32768, 5));
    send_frame(frame_of(-32768, -32768, -32768, 32767, 32767, 32767, -5));
    send_frame(frame_of(0, 0, 0, 0, 0, 0, 0));
    drain_results();
    write_register(isc_pkg::REG_ACC_X_OFF, ACC_OFF_MAX);
    write_register(isc_pkg::REG_ACC_Y_OFF, -ACC_OFF_MAX - 1);
    write_register(isc_pkg::REG_ACC_Z_OFF, ACC_OFF_MAX);
    write_register(isc_pkg::REG_RATE_X_OFF, RATE_OFF_MAX);
    write_register(isc_pkg::REG_RATE_Y_OFF, -RATE_OFF_MAX - 1);
    write_register(isc_pkg::REG_RATE_Z_OFF, -RATE_OFF_MAX - 1);
    send_frame(frame_of(12000, -12000, 0, 30000, -30000, 0, 9));
    send_frame(frame_of(-32768, 32767, -32768, 32767, -32768, 32767, -9));
    send_frame(frame_of(4096, -4096, 8192, 131, -131, 262, 340));
    send_frame(frame_of(0, 0, 0, 0, 0, 0, 0));
    drain_results();
  endtask

  // A shift write must leave the history and smoother untouched.
  task automatic test_shift_write_keeps_state();
    write_register(isc_pkg::REG_ACC_X_OFF, random_acc_offset());
    write_register(isc_pkg::REG_RATE_Y_OFF, random_rate_offset());
    write_register(isc_pkg::REG_ACC_SHIFT, 2);
    write_register(isc_pkg::REG_RATE_SHIFT, 5);
    send_random(15);
    drain_results();
    write_register(isc_pkg::REG_ACC_SHIFT, $urandom_range(0, 15));
    write_register(isc_pkg::REG_RATE_SHIFT, $urandom_range(0, 15));
    send_random(15);
    drain_results();
  endtask

  // The sink holds off long enough for the pipeline to fill and stall the input.
  task automatic test_output_hold_off();
    sink_hold_cycles = 150;
    send_random(40);
    drain_results();
  endtask

  task automatic test_steady_stream();
    no_idle = 1'b1;
    send_random(100);
    drain_results();
    no_idle = 1'b0;
  endtask

  task automatic test_random_configs();
    for (int phase = 0; phase < 5; phase++) begin
      write_register(isc_pkg::REG_ACC_SHIFT, $urandom_range(0, 15));
      write_register(isc_pkg::REG_RATE_SHIFT, $urandom_range(0, 15));
      if ($urandom_range(0, 1)) write_register(isc_pkg::REG_ACC_X_OFF, random_acc_offset());
      if ($urandom_range(0, 1)) write_register(isc_pkg::REG_ACC_Y_OFF, random_acc_offset());
      if ($urandom_range(0, 1)) write_register(isc_pkg::REG_ACC_Z_OFF, random_acc_offset());
      if ($urandom_range(0, 1)) write_register(isc_pkg::REG_RATE_X_OFF, random_rate_offset());
      if ($urandom_range(0, 1)) write_register(isc_pkg::REG_RATE_Y_OFF, random_rate_offset());
      if ($urandom_range(0, 1)) write_register(isc_pkg::REG_RATE_Z_OFF, random_rate_offset());
      send_random(86);
      drain_results();
    end
  endtask

  initial begin
    for (int i = 0; i < 3; i++) begin
      acc_off[i] = 0;
      rate_off[i] = 0;
    end
    acc_shift = isc_pkg::ACC_SHIFT_RST;
    rate_shift = isc_pkg::RATE_SHIFT_RST;
    clear_filter_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_priming();
    test_register_extremes();
    test_shift_write_keeps_state();
    test_output_hold_off();
    test_steady_stream();
    test_random_configs();

    drain_results();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("%0t ERROR run did not finish within %0d cycles", $time, RUN_LIMIT);
    $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
